[rtl/core/tfcc_pkg.sv]
`default_nettype none

package tfcc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned STAT_W  = 2;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
  localparam logic [POS_W-1:0]  POS_TEMP_LO = 4'd0;
  localparam logic [POS_W-1:0]  POS_TEMP_HI = 4'd1;
  localparam logic [POS_W-1:0]  POS_CONFIG  = 4'd4;
  localparam logic [POS_W-1:0]  POS_LAST    = 4'd8;

  localparam logic [BYTE_W-1:0] RES_9BIT  = 8'h1F;
  localparam logic [BYTE_W-1:0] RES_10BIT = 8'h3F;
  localparam logic [BYTE_W-1:0] RES_11BIT = 8'h5F;
  localparam logic [BYTE_W-1:0] RES_12BIT = 8'h7F;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_CFG = 2'd1,
    STATUS_BAD_CRC = 2'd2
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic signed [TEMP_W-1:0] temperature;
  } result_t;

  typedef struct packed {
    logic             fire;
    logic [POS_W-1:0] pos;
  } frame_stat_t;

  // Reflected CRC-8, LSB first: eight shift steps on one byte.
  function automatic logic [BYTE_W-1:0] crc_fold(input logic [BYTE_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] crc;
    logic              fb;
    crc = crc_in;
    for (int k = 0; k < BYTE_W; k++) begin
      fb  = crc[0] ^ data[k];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic logic valid_resolution(input logic [BYTE_W-1:0] b);
    return (b == RES_9BIT) || (b == RES_10BIT) || (b == RES_11BIT) || (b == RES_12BIT);
  endfunction

endpackage

`default_nettype wire

[rtl/core/tfcc_frame.sv]
`default_nettype none

module tfcc_frame
  import tfcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] frame_byte,
  input  wire logic              frame_start,
  output frame_stat_t            stat,
  output result_t                result
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [BYTE_W-1:0] temp_lo_r, temp_lo_nxt;
  logic [BYTE_W-1:0] temp_hi_r, temp_hi_nxt;
  logic              res_ok_r, res_ok_nxt;

  logic [POS_W-1:0]  pos_cur;
  logic [BYTE_W-1:0] crc_cur;
  logic              is_last;

  always_comb begin
    // frame start forces this byte to be byte 0 with a fresh CRC
    pos_cur = frame_start ? '0 : pos_r;
    crc_cur = frame_start ? '0 : crc_r;
    is_last = (pos_cur >= POS_LAST);

    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    temp_lo_nxt = temp_lo_r;
    temp_hi_nxt = temp_hi_r;
    res_ok_nxt  = res_ok_r;

    if (accept) begin
      if (is_last) begin
        pos_nxt = '0;
        crc_nxt = '0;
      end else begin
        pos_nxt = pos_cur + 1'b1;
        crc_nxt = crc_fold(crc_cur, frame_byte);
        if (pos_cur == POS_TEMP_LO) begin
          temp_lo_nxt = frame_byte;
        end else if (pos_cur == POS_TEMP_HI) begin
          temp_hi_nxt = frame_byte;
        end else if (pos_cur == POS_CONFIG) begin
          res_ok_nxt = valid_resolution(frame_byte);
        end
      end
    end

    stat.fire = accept && is_last;
    stat.pos  = pos_r;

    if (!res_ok_r) begin
      result.status      = STATUS_BAD_CFG;
      result.temperature = '0;
    end else if (crc_cur != frame_byte) begin
      result.status      = STATUS_BAD_CRC;
      result.temperature = '0;
    end else begin
      result.status      = STATUS_OK;
      result.temperature = {temp_hi_r, temp_lo_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      crc_r     <= '0;
      temp_lo_r <= '0;
      temp_hi_r <= '0;
      res_ok_r  <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      temp_lo_r <= temp_lo_nxt;
      temp_hi_r <= temp_hi_nxt;
      res_ok_r  <= res_ok_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tfcc_out.sv]
`default_nettype none

module tfcc_out
  import tfcc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t result,
  input  wire logic    out_stall,
  output logic         full,
  output logic         out_valid,
  output result_t      out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    // drop the request once taken, then load a new one if any
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign full      = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

[rtl/core/temperature_frame_crc_checker.sv]
`default_nettype none
// A frame's result shows in the cycle after its ninth byte is accepted.
// Throughput: one byte per cycle while in_stall is low; the CRC byte update and
// the frame checks sit between the framing registers and a single output register.
// Input stalls only while the output register holds a request that is stalled.
// Synchronous active-low reset clears the framing position, CRC and output valid.

module temperature_frame_crc_checker
  import tfcc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [BYTE_W-1:0]        in_frame_byte,
  input  wire logic                     in_frame_start,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [STAT_W-1:0]             out_status,
  output logic signed [TEMP_W-1:0]      out_temperature
);

  logic        in_accept;
  logic        out_full;
  frame_stat_t frame_stat;
  result_t     frame_result;
  result_t     out_data;

  assign in_stall  = out_full;
  assign in_accept = in_valid && !out_full;

  tfcc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .frame_byte  (in_frame_byte),
    .frame_start (in_frame_start),
    .stat        (frame_stat),
    .result      (frame_result)
  );

  tfcc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (frame_stat.fire),
    .result    (frame_result),
    .out_stall (out_stall),
    .full      (out_full),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_status      = out_data.status;
  assign out_temperature = out_data.temperature;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_stat.pos <= POS_LAST)
    else $error("frame position beyond last byte");

  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    frame_stat.fire |=> out_valid)
    else $error("completed frame produced no result");

  a_err_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STATUS_OK)) |-> (out_temperature == '0))
    else $error("error result carries a temperature");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_BAD_CFG ||
                   out_status == STATUS_BAD_CRC))
    else $error("undefined status code");

endmodule

`default_nettype wire
